### rtl/sitd_pkg.sv
package sitd_pkg;

  // default width of the integer taken in
  localparam int VALUE_WIDTH_DEF = 32;

  // ASCII codes used on the result side
  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_NINE  = 8'h39;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_EMIT
  } sitd_state_t;

  // double-dabble correction of one BCD digit before the next shift
  function automatic logic [3:0] dd_adjust(input logic [3:0] d);
    dd_adjust = (d >= 4'd5) ? (d + 4'd3) : d;
  endfunction

endpackage

### rtl/signed_int_to_decimal_ascii.sv
// Signed integer to decimal ASCII text.
// Input channel in_*: one item is one two's-complement integer of VALUE_WIDTH
// bits in the low bits of in_tdata (upper pad bits ignored).
// Result channel out_*: one ASCII character per item in out_tdata, most
// significant first; '-' leads a negative number, zero prints as '0', no
// leading zeros. out_tlast marks the final character of each number.
// Timing: the magnitude is converted by a shift-and-add-3 unit, one input bit
// per cycle. Leading zero digits of the NDIG-digit result (NDIG = 10 for 32
// bits) are then dropped one at a time, and the characters leave at one per
// cycle while out_tready is high. One number is in flight at a time;
// in_tready is high only between numbers, and the next number is taken while
// the final character of the previous one still waits in the output register.
// Stall: when out_tready is low the output register holds its character and
// the controller waits; nothing is dropped.
// Reset (rst_n low, synchronous): controller returns to idle, output empty.
module signed_int_to_decimal_ascii #(
  parameter int VALUE_WIDTH = sitd_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [((VALUE_WIDTH + 7) / 8)*8-1:0] in_tdata,   // [VALUE_WIDTH-1:0] value
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [7:0]                           out_tdata,  // [7:0] character
  output logic                                 out_tlast
);

  // decimal digits needed for any VALUE_WIDTH-bit magnitude
  localparam int NDIG = (VALUE_WIDTH * 1233) / 4096 + 1;
  localparam int LW   = $clog2(NDIG + 1);

  sitd_pkg::sitd_state_t state_r, state_nxt;

  logic [NDIG*4-1:0]      dig_r, dig_nxt;
  logic [LW-1:0]          left_r, left_nxt;
  logic                   neg_r, neg_nxt;
  logic                   out_tvalid_r, out_tvalid_nxt;
  logic [7:0]             out_char_r, out_char_nxt;
  logic                   out_last_r, out_last_nxt;
  logic                   start;
  logic                   conv_done;
  logic [NDIG*4-1:0]      conv_bcd;
  logic [VALUE_WIDTH-1:0] value_w;
  logic [VALUE_WIDTH-1:0] mag;
  logic [3:0]             top_dig;
  logic                   out_free;

  // magnitude, most negative value comes out as the unsigned 2^(W-1)
  assign value_w = in_tdata[VALUE_WIDTH-1:0];
  assign mag     = value_w[VALUE_WIDTH-1] ? (~value_w + VALUE_WIDTH'(1)) : value_w;

  sitd_dabble #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .NDIG        (NDIG)
  ) u_dabble (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .mag   (mag),
    .done  (conv_done),
    .bcd   (conv_bcd)
  );

  assign top_dig  = dig_r[NDIG*4-1 -: 4];
  assign out_free = !out_tvalid_r || out_tready;

  // controller: convert, drop leading zeros, emit sign and digits
  always_comb begin
    state_nxt      = state_r;
    dig_nxt        = dig_r;
    left_nxt       = left_r;
    neg_nxt        = neg_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_char_nxt   = out_char_r;
    out_last_nxt   = out_last_r;
    start          = 1'b0;
    in_tready      = 1'b0;
    case (state_r)
      sitd_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          neg_nxt   = value_w[VALUE_WIDTH-1];
          start     = 1'b1;
          state_nxt = sitd_pkg::ST_CONV;
        end
      end
      sitd_pkg::ST_CONV: begin
        if (conv_done) begin
          dig_nxt   = conv_bcd;
          left_nxt  = LW'(NDIG);
          state_nxt = sitd_pkg::ST_SKIP;
        end
      end
      sitd_pkg::ST_SKIP: begin
        // keep at least one digit so that zero prints as '0'
        if (top_dig == 4'd0 && left_r != LW'(1)) begin
          dig_nxt  = {dig_r[NDIG*4-5:0], 4'h0};
          left_nxt = left_r - LW'(1);
        end else if (neg_r) begin
          state_nxt = sitd_pkg::ST_SIGN;
        end else begin
          state_nxt = sitd_pkg::ST_EMIT;
        end
      end
      sitd_pkg::ST_SIGN: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_char_nxt   = sitd_pkg::ASCII_MINUS;
          out_last_nxt   = 1'b0;
          state_nxt      = sitd_pkg::ST_EMIT;
        end
      end
      sitd_pkg::ST_EMIT: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_char_nxt   = sitd_pkg::ASCII_ZERO | {4'h0, top_dig};
          out_last_nxt   = (left_r == LW'(1));
          dig_nxt        = {dig_r[NDIG*4-5:0], 4'h0};
          left_nxt       = left_r - LW'(1);
          if (left_r == LW'(1)) begin
            state_nxt = sitd_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = sitd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= sitd_pkg::ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    dig_r      <= dig_nxt;
    left_r     <= left_nxt;
    neg_r      <= neg_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_char_r;
  assign out_tlast  = out_last_r;

`ifndef NO_ASSERTIONS
  // an accepted item always starts a conversion
  a_accept_conv: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == sitd_pkg::ST_CONV))
    else $error("accepted item did not start conversion");

  // digits still to emit whenever emitting
  a_emit_left: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sitd_pkg::ST_EMIT) |-> (left_r != '0))
    else $error("emit state with no digits left");

  // every character is a minus sign or a decimal digit
  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata == sitd_pkg::ASCII_MINUS ||
                    (out_tdata >= sitd_pkg::ASCII_ZERO && out_tdata <= sitd_pkg::ASCII_NINE)))
    else $error("character out of range");

  // the sign never ends a number
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata == sitd_pkg::ASCII_MINUS) |-> !out_tlast)
    else $error("minus sign flagged as last");
`endif

endmodule

### rtl/sitd_dabble.sv
module sitd_dabble #(
  parameter int VALUE_WIDTH = sitd_pkg::VALUE_WIDTH_DEF,
  parameter int NDIG        = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] mag,
  output logic                   done,
  output logic [NDIG*4-1:0]      bcd
);

  localparam int CW = $clog2(VALUE_WIDTH + 1);

  logic [VALUE_WIDTH-1:0] bin_r, bin_nxt;
  logic [NDIG*4-1:0]      bcd_r, bcd_nxt;
  logic [NDIG*4-1:0]      adj;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic                   done_r, done_nxt;

  // add-3 correction on every digit, all digits independent
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      adj[i*4 +: 4] = sitd_pkg::dd_adjust(bcd_r[i*4 +: 4]);
    end
  end

  // one binary bit moves into the BCD register per cycle, MSB first
  always_comb begin
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      bin_nxt = mag;
      bcd_nxt = '0;
      cnt_nxt = CW'(VALUE_WIDTH);
    end else if (cnt_r != '0) begin
      bin_nxt  = {bin_r[VALUE_WIDTH-2:0], 1'b0};
      bcd_nxt  = {adj[NDIG*4-2:0], bin_r[VALUE_WIDTH-1]};
      cnt_nxt  = cnt_r - CW'(1);
      done_nxt = (cnt_r == CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  // payload shift registers
  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign done = done_r;
  assign bcd  = bcd_r;

endmodule
